// ===== sv/register_multiply_divide_unit_macros.svh =====
// ---------------------------------------------------------------------------
// register_multiply_divide_unit_macros
// assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef REGISTER_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define REGISTER_MULTIPLY_DIVIDE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RMDU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmdu check failed");

// next-cycle implication, disabled in reset
`define RMDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmdu check failed");

`endif

// ===== sv/rmdu_pkg.sv =====
// ---------------------------------------------------------------------------
// rmdu_pkg
// register indexes, divide sequencing constants and control structs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmdu_pkg;

  // bus access kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // register offsets from base
  localparam logic [4:0] IDX_MCAND    = 5'h02;
  localparam logic [4:0] IDX_MULTIPLY = 5'h03;
  localparam logic [4:0] IDX_DVD_LO   = 5'h04;
  localparam logic [4:0] IDX_DVD_HI   = 5'h05;
  localparam logic [4:0] IDX_DIVIDE   = 5'h06;
  localparam logic [4:0] IDX_QUOT_LO  = 5'h14;
  localparam logic [4:0] IDX_QUOT_HI  = 5'h15;
  localparam logic [4:0] IDX_PR_LO    = 5'h16;
  localparam logic [4:0] IDX_PR_HI    = 5'h17;

  localparam logic [15:0] DIV_ZERO_QUOT = 16'hFFFF;

  // one quotient bit per step
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // controller to datapath commands
  typedef struct packed {
    logic load_mcand;
    logic multiply;
    logic load_dvd_lo;
    logic load_dvd_hi;
    logic div_zero;
    logic div_start;
    logic div_step;
    logic capture_read;
  } rmdu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic divisor_zero;
  } rmdu_stat_t;

endpackage

`default_nettype wire

// ===== sv/rmdu_if.sv =====
// ---------------------------------------------------------------------------
// rmdu_if
// request and response channels of the multiply/divide unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rmdu_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [4:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, command, reg_index, write_data, input ready);
  modport sink   (input valid, command, reg_index, write_data, output ready);
endinterface

interface rmdu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== sv/rmdu_dpath.sv =====
// ---------------------------------------------------------------------------
// rmdu_dpath
// operand and result registers, 8x8 multiplier, restoring divide step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmdu_dpath
  import rmdu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rmdu_cmd_t  cmd,
  input  wire logic [4:0] reg_index,
  input  wire logic [7:0] write_data,
  output rmdu_stat_t      stat,
  output logic [7:0]      read_data
);

  logic [7:0]  multiplicand;
  logic [15:0] dividend;
  logic [15:0] quotient;
  logic [15:0] product_or_remainder;
  logic [7:0]  divisor;

  logic [15:0] product;
  logic [8:0]  trial;
  logic [8:0]  diff;
  logic        qbit;
  logic [7:0]  rem_next;
  logic [7:0]  read_mux;

  assign stat.divisor_zero = (write_data == 8'd0);

  // unsigned 8x8 product
  assign product = {8'd0, multiplicand} * {8'd0, write_data};

  // one restoring step: remainder lives in the low byte of product_or_remainder
  assign trial    = {product_or_remainder[7:0], quotient[15]};
  assign diff     = trial - {1'b0, divisor};
  assign qbit     = (trial >= {1'b0, divisor});
  assign rem_next = qbit ? diff[7:0] : trial[7:0];

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplicand         <= '0;
      dividend             <= '0;
      quotient             <= '0;
      product_or_remainder <= '0;
    end else begin
      if (cmd.load_mcand) begin
        multiplicand <= write_data;
      end
      if (cmd.load_dvd_lo) begin
        dividend[7:0] <= write_data;
      end
      if (cmd.load_dvd_hi) begin
        dividend[15:8] <= write_data;
      end
      if (cmd.multiply) begin
        product_or_remainder <= product;
        quotient             <= '0;
      end
      if (cmd.div_zero) begin
        quotient             <= DIV_ZERO_QUOT;
        product_or_remainder <= dividend;
      end
      if (cmd.div_start) begin
        quotient             <= dividend;
        product_or_remainder <= '0;
      end
      if (cmd.div_step) begin
        quotient             <= {quotient[14:0], qbit};
        product_or_remainder <= {8'd0, rem_next};
      end
    end
  end

  // divisor held for the whole divide
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      divisor <= write_data;
    end
  end

  // read select
  always_comb begin
    unique case (reg_index)
      IDX_QUOT_LO: read_mux = quotient[7:0];
      IDX_QUOT_HI: read_mux = quotient[15:8];
      IDX_PR_LO:   read_mux = product_or_remainder[7:0];
      IDX_PR_HI:   read_mux = product_or_remainder[15:8];
      default:     read_mux = 8'd0;
    endcase
  end

  // response word register
  always_ff @(posedge clk) begin
    if (cmd.capture_read) begin
      read_data <= read_mux;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rmdu_ctrl.sv =====
// ---------------------------------------------------------------------------
// rmdu_ctrl
// access decode, divide sequencer and response valid
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmdu_ctrl
  import rmdu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic       command,
  input  wire logic [4:0] reg_index,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  input  wire rmdu_stat_t stat,
  output rmdu_cmd_t       cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             wr;
  logic             rd;
  logic             last_step;

  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign wr        = accept && (command == CMD_WRITE);
  assign rd        = accept && (command == CMD_READ);
  assign last_step = (cnt == CNT_W'(DIV_STEPS - 1));

  // command decode
  always_comb begin
    cmd              = '0;
    cmd.load_mcand   = wr && (reg_index == IDX_MCAND);
    cmd.multiply     = wr && (reg_index == IDX_MULTIPLY);
    cmd.load_dvd_lo  = wr && (reg_index == IDX_DVD_LO);
    cmd.load_dvd_hi  = wr && (reg_index == IDX_DVD_HI);
    cmd.div_zero     = wr && (reg_index == IDX_DIVIDE) && stat.divisor_zero;
    cmd.div_start    = wr && (reg_index == IDX_DIVIDE) && !stat.divisor_zero;
    cmd.div_step     = (state == ST_DIV);
    cmd.capture_read = rd;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.div_start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, step counter, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_start) begin
        cnt <= '0;
      end else if (state == ST_DIV) begin
        cnt <= cnt + 1'b1;
      end
      if (rd) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/register_multiply_divide_unit.sv =====
// ---------------------------------------------------------------------------
// register_multiply_divide_unit
// register-mapped 8x8 multiply and 16/8 divide unit
// ---------------------------------------------------------------------------
// usage:
//   req carries one bus access per word: command (0 write, 1 read),
//   reg_index and write_data. rsp returns one read_data word per read;
//   writes return nothing. reads of unmapped indexes return zero.
// sequencing and throughput:
//   a read word appears on rsp in the cycle after it is accepted.
//   multiply and operand writes complete in the cycle they are accepted.
//   a divide by a nonzero byte produces one quotient bit per cycle
//   through a single restoring subtract step; req.ready is low meanwhile.
//   a divide by zero completes at once (quotient 0xFFFF, remainder =
//   dividend).
// reset:
//   synchronous on rst; operand and result registers but the divisor
//   clear to zero, and no response is pending.
// stalls:
//   the response register holds its word while rsp.ready is low; req.ready
//   drops until that word is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module register_multiply_divide_unit
  import rmdu_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  rmdu_req_if.sink   req,
  rmdu_rsp_if.source rsp
);

  rmdu_cmd_t  cmd;
  rmdu_stat_t stat;

  // sequencing and handshake control
  rmdu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .command   (req.command),
    .reg_index (req.reg_index),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and registers
  rmdu_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .reg_index  (req.reg_index),
    .write_data (req.write_data),
    .stat       (stat),
    .read_data  (rsp.read_data)
  );

endmodule

`default_nettype wire

// ===== sv/rmdu_checker.sv =====
// ---------------------------------------------------------------------------
// rmdu_checker
// port-level checks of the multiply/divide unit, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "register_multiply_divide_unit_macros.svh"

module rmdu_props
  import rmdu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       command,
  input wire logic [4:0] reg_index,
  input wire logic [7:0] write_data,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] read_data
);

  logic req_acc;
  logic div_go;

  assign req_acc = req_valid && req_ready;
  assign div_go  = req_acc && (command == CMD_WRITE) && (reg_index == IDX_DIVIDE)
                   && (write_data != 8'd0);

  // a stalled response word holds
  `RMDU_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(read_data))

  // every accepted read shows up on the next cycle
  `RMDU_ASSERT_NEXT(a_read_resp, clk, rst, req_acc && (command == CMD_READ), rsp_valid)

  // a nonzero divide blocks new accesses as it begins to iterate
  `RMDU_ASSERT_NEXT(a_div_busy, clk, rst, div_go, !req_ready)

  // no access is taken while a response is stuck
  `RMDU_ASSERT_NOW(a_no_overrun, clk, rst, rsp_valid && !rsp_ready, !req_ready)

endmodule

bind register_multiply_divide_unit rmdu_props u_rmdu_props (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .command    (req.command),
  .reg_index  (req.reg_index),
  .write_data (req.write_data),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_data  (rsp.read_data)
);

`default_nettype wire
